// ----- hw/rtl/whsp_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// whsp_pkg
// Shared types, tag constants and byte helpers for the WAV header parser.
// ============================================================================
package whsp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    // header byte positions
    localparam logic [4:0] POS_RIFF_END  = 5'd4;
    localparam logic [4:0] POS_WAVE_BEG  = 5'd8;
    localparam logic [4:0] POS_WAVE_END  = 5'd12;
    localparam logic [4:0] POS_HEAD_LAST = 5'd11;
    // fmt chunk byte positions
    localparam logic [4:0] POS_CH_LO     = 5'd6;
    localparam logic [4:0] POS_CH_HI     = 5'd7;
    localparam logic [4:0] POS_RATE_LO   = 5'd8;
    localparam logic [4:0] POS_RATE_HI   = 5'd11;
    localparam logic [4:0] POS_DEPTH_LO  = 5'd18;
    localparam logic [4:0] POS_FMT_LAST  = 5'd19;
    localparam logic [4:0] POS_SIZE_LAST = 5'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEAD    = 3'd0,
        PH_SCAN    = 3'd1,
        PH_FMT     = 3'd2,
        PH_DSIZE   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_REJECT  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_REJECT  = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [31:0] data_bytes;
        logic        accepted;
        logic        end_of_run;
    } out_item_t;

    // up to two results per input byte; push1 only ever carries done
    typedef struct packed {
        logic      push0;
        logic      push1;
        out_item_t item0;
        out_item_t item1;
    } push_t;

    // byte 0 is the first byte on the wire (most significant of the tag)
    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0: r = tag[31:24];
            2'd1: r = tag[23:16];
            2'd2: r = tag[15:8];
            2'd3: r = tag[7:0];
            default: r = tag[7:0];
        endcase
        return r;
    endfunction

    // little-endian byte insert
    function automatic logic [31:0] put_word(input logic [31:0] w, input logic [7:0] b,
                                             input logic [1:0] idx);
        logic [31:0] r;
        r = w;
        unique case (idx)
            2'd0: r[7:0]   = b;
            2'd1: r[15:8]  = b;
            2'd2: r[23:16] = b;
            2'd3: r[31:24] = b;
            default: r[7:0] = b;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] put_half(input logic [15:0] h, input logic [7:0] b,
                                             input logic idx);
        logic [15:0] r;
        r = h;
        if (idx)
        begin
            r[15:8] = b;
        end
        else
        begin
            r[7:0] = b;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/wav_header_stream_parser_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// wav_header_stream_parser_top
// WAV/RIFF header parser: checks the file tags, latches format fields,
// reports the data header and forwards the data chunk bytes.
// ----------------------------------------------------------------------------
// Usage:
//   byte_*   : input channel, one file byte per transaction, final_byte set on
//              the last byte of the file.
//   result_* : output channel, zero, one or two results per input byte
//              (payload, header, reject, done); end_of_run marks the last
//              result of a byte.
//   Each result is written into the result queue as its byte is accepted.
//   Throughput: one byte per cycle while each byte yields at most one result
//   and result_ready stays high; a byte with a result plus done needs a
//   second pop. The rate is set by the four-entry queue's single output port.
//   byte_ready is high while the queue has room for two results, so a byte
//   is taken even while a finished result waits for result_ready.
//   When the receiver stalls the queue fills and byte_ready drops; no result
//   is lost. Reset clears the parser to the start-of-file state and empties
//   the queue. After a done result the parser restarts on the next byte.
// ============================================================================
module wav_header_stream_parser_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  whsp_pkg::in_item_t   byte_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output whsp_pkg::out_item_t  result_data
);
    import whsp_pkg::*;

    push_t push;
    logic  fire;

    assign fire = byte_valid && byte_ready;

    whsp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (byte_data),
        .push  (push)
    );

    whsp_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .space        (byte_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

// ----- hw/rtl/whsp_parser.sv -----
`timescale 1ns / 1ps
// ============================================================================
// whsp_parser
// Parse state machine: one byte per transaction, up to two results pushed.
// ============================================================================
module whsp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  whsp_pkg::in_item_t  item,
    output whsp_pkg::push_t     push
);
    import whsp_pkg::*;

    phase_t      phase_reg,   phase_next,   phase_upd;
    logic [23:0] window_reg,  window_next,  window_upd;
    logic [1:0]  fill_reg,    fill_next,    fill_upd;
    logic [4:0]  pos_reg,     pos_next,     pos_upd;
    logic [31:0] remain_reg,  remain_next,  remain_upd;
    logic [15:0] chan_reg,    chan_next,    chan_upd;
    logic [31:0] rate_reg,    rate_next,    rate_upd;
    logic [15:0] depth_reg,   depth_next,   depth_upd;
    logic [31:0] size_reg,    size_next,    size_upd;
    logic        loaded_reg,  loaded_next,  loaded_upd;

    logic [7:0]  b;
    logic [31:0] word;
    logic        head_mismatch;
    logic        tag_hit;

    assign b    = item.in_byte;
    assign word = {window_reg, b};
    assign tag_hit = (fill_reg == 2'd3) && ((word == TAG_FMT) || (word == TAG_DATA));
    assign head_mismatch =
        ((pos_reg < POS_RIFF_END) && (b != tag_byte(TAG_RIFF, pos_reg[1:0]))) ||
        ((pos_reg >= POS_WAVE_BEG) && (pos_reg < POS_WAVE_END) &&
         (b != tag_byte(TAG_WAVE, pos_reg[1:0])));

    // next state and datapath update
    always_comb
    begin
        phase_upd  = phase_reg;
        window_upd = window_reg;
        fill_upd   = fill_reg;
        pos_upd    = pos_reg;
        remain_upd = remain_reg;
        chan_upd   = chan_reg;
        rate_upd   = rate_reg;
        depth_upd  = depth_reg;
        size_upd   = size_reg;
        loaded_upd = loaded_reg;
        unique case (phase_reg)
            PH_HEAD:
            begin
                if (head_mismatch)
                begin
                    phase_upd = PH_REJECT;
                end
                else if (pos_reg >= POS_HEAD_LAST)
                begin
                    loaded_upd = 1'b1;
                    phase_upd  = PH_SCAN;
                    pos_upd    = '0;
                    window_upd = '0;
                    fill_upd   = '0;
                end
                else
                begin
                    pos_upd = pos_reg + 5'd1;
                end
            end
            PH_SCAN:
            begin
                if (tag_hit)
                begin
                    phase_upd  = (word == TAG_FMT) ? PH_FMT : PH_DSIZE;
                    pos_upd    = '0;
                    window_upd = '0;
                    fill_upd   = '0;
                    if (word == TAG_DATA)
                    begin
                        size_upd = '0;
                    end
                end
                else
                begin
                    window_upd = word[23:0];
                    if (fill_reg != 2'd3)
                    begin
                        fill_upd = fill_reg + 2'd1;
                    end
                end
            end
            PH_FMT:
            begin
                if ((pos_reg == POS_CH_LO) || (pos_reg == POS_CH_HI))
                begin
                    chan_upd = put_half(chan_reg, b, pos_reg[0]);
                end
                else if ((pos_reg >= POS_RATE_LO) && (pos_reg <= POS_RATE_HI))
                begin
                    rate_upd = put_word(rate_reg, b, pos_reg[1:0]);
                end
                else if ((pos_reg == POS_DEPTH_LO) || (pos_reg == POS_FMT_LAST))
                begin
                    depth_upd = put_half(depth_reg, b, pos_reg[0]);
                end
                if (pos_reg >= POS_FMT_LAST)
                begin
                    phase_upd = PH_SCAN;
                    pos_upd   = '0;
                end
                else
                begin
                    pos_upd = pos_reg + 5'd1;
                end
            end
            PH_DSIZE:
            begin
                size_upd = put_word(size_reg, b, pos_reg[1:0]);
                if (pos_reg >= POS_SIZE_LAST)
                begin
                    pos_upd    = '0;
                    remain_upd = size_upd;
                    phase_upd  = (size_upd == '0) ? PH_SCAN : PH_PAYLOAD;
                end
                else
                begin
                    pos_upd = pos_reg + 5'd1;
                end
            end
            PH_PAYLOAD:
            begin
                remain_upd = remain_reg - 32'd1;
                if (remain_upd == '0)
                begin
                    phase_upd  = PH_SCAN;
                    window_upd = '0;
                    fill_upd   = '0;
                end
            end
            default:
            begin
                phase_upd = PH_REJECT;
            end
        endcase
    end

    // the last byte of a file returns everything to reset
    always_comb
    begin
        if (fire && item.final_byte)
        begin
            phase_next  = PH_HEAD;
            window_next = '0;
            fill_next   = '0;
            pos_next    = '0;
            remain_next = '0;
            chan_next   = '0;
            rate_next   = '0;
            depth_next  = '0;
            size_next   = '0;
            loaded_next = 1'b0;
        end
        else if (fire)
        begin
            phase_next  = phase_upd;
            window_next = window_upd;
            fill_next   = fill_upd;
            pos_next    = pos_upd;
            remain_next = remain_upd;
            chan_next   = chan_upd;
            rate_next   = rate_upd;
            depth_next  = depth_upd;
            size_next   = size_upd;
            loaded_next = loaded_upd;
        end
        else
        begin
            phase_next  = phase_reg;
            window_next = window_reg;
            fill_next   = fill_reg;
            pos_next    = pos_reg;
            remain_next = remain_reg;
            chan_next   = chan_reg;
            rate_next   = rate_reg;
            depth_next  = depth_reg;
            size_next   = size_reg;
            loaded_next = loaded_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            window_reg <= '0;
            fill_reg   <= '0;
            pos_reg    <= '0;
            remain_reg <= '0;
            chan_reg   <= '0;
            rate_reg   <= '0;
            depth_reg  <= '0;
            size_reg   <= '0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            depth_reg  <= depth_next;
            size_reg   <= size_next;
            loaded_reg <= loaded_next;
        end
    end

    // result generation; results carry the values as updated by this byte
    logic  prim_valid;
    kind_t prim_kind;
    logic [7:0] prim_byte;
    out_item_t prim_item, done_item;

    always_comb
    begin
        prim_valid = 1'b0;
        prim_kind  = KIND_PAYLOAD;
        prim_byte  = '0;
        unique case (phase_reg)
            PH_HEAD:
            begin
                prim_valid = head_mismatch;
                prim_kind  = KIND_REJECT;
            end
            PH_DSIZE:
            begin
                prim_valid = (pos_reg >= POS_SIZE_LAST);
                prim_kind  = KIND_HEADER;
            end
            PH_PAYLOAD:
            begin
                prim_valid = 1'b1;
                prim_kind  = KIND_PAYLOAD;
                prim_byte  = b;
            end
            default:
            begin
                prim_valid = 1'b0;
            end
        endcase

        prim_item.result_kind     = prim_kind;
        prim_item.payload_byte    = prim_byte;
        prim_item.channel_count   = chan_upd;
        prim_item.sample_rate     = rate_upd;
        prim_item.bits_per_sample = depth_upd;
        prim_item.data_bytes      = size_upd;
        prim_item.accepted        = 1'b0;
        prim_item.end_of_run      = !item.final_byte;

        done_item.result_kind     = KIND_DONE;
        done_item.payload_byte    = '0;
        done_item.channel_count   = chan_upd;
        done_item.sample_rate     = rate_upd;
        done_item.bits_per_sample = depth_upd;
        done_item.data_bytes      = size_upd;
        done_item.accepted        = loaded_upd;
        done_item.end_of_run      = 1'b1;

        push.push0 = fire && (prim_valid || item.final_byte);
        push.push1 = fire && prim_valid && item.final_byte;
        push.item0 = prim_valid ? prim_item : done_item;
        push.item1 = done_item;
    end

    a_second_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        push.push1 |-> (push.push0 && (push.item1.result_kind == KIND_DONE)))
        else $error("second result of a byte is not a done result");

    a_reject_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (push.push0 && (push.item0.result_kind == KIND_REJECT) && !item.final_byte)
        |=> (phase_reg == PH_REJECT))
        else $error("parser left reject phase before end of file");

endmodule

// ----- hw/rtl/whsp_out_fifo.sv -----
`timescale 1ns / 1ps
// ============================================================================
// whsp_out_fifo
// Small result queue: two pushes and one pop per cycle, registered head.
// ============================================================================
module whsp_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  whsp_pkg::push_t      push,
    output logic                 space,
    output logic                 result_valid,
    input  logic                 result_ready,
    output whsp_pkg::out_item_t  result_data
);
    import whsp_pkg::*;

    out_item_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    head_reg, head_next;
    logic [FIFO_AW-1:0]    tail_reg, tail_next;
    logic [FIFO_CW-1:0]    count_reg, count_next;
    logic [FIFO_AW-1:0]    tail_plus;
    logic                  pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result_data  = mem_reg[head_reg];
    // room for the worst case of two results from the next byte
    assign space        = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign tail_plus    = tail_reg + FIFO_AW'(1);

    always_comb
    begin
        head_next  = pop ? (head_reg + FIFO_AW'(1)) : head_reg;
        tail_next  = tail_reg + FIFO_AW'(push.push0) + FIFO_AW'(push.push1);
        count_next = count_reg + FIFO_CW'(push.push0) + FIFO_CW'(push.push1)
                     - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem_reg[tail_reg] <= push.item0;
        end
        if (push.push1)
        begin
            mem_reg[tail_plus] <= push.item1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.push0 |-> (count_reg <= FIFO_CW'(FIFO_DEPTH - 2)))
        else $error("result queue pushed without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= FIFO_CW'(FIFO_DEPTH)) && (result_valid == (count_reg != '0)))
        else $error("result queue count out of range");

endmodule
